>>> sv/gnos_pkg.sv
// ----------------------------------------------------------------------------
// gnos_pkg
// Shared types and constants of the grid nearest obstacle search block.
// ----------------------------------------------------------------------------
package gnos_pkg;

    localparam int GRID_SIDE_DEF = 8;

    localparam logic [3:0]  SIDE_RESET   = 4'd7;
    localparam logic [13:0] LIMIT_RESET  = 14'd10000;
    localparam int          DIST_MAX_OUT = 127;

    // result status codes
    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_BLOCKED = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // configuration register indexes
    localparam logic CFG_SIDE  = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_QUERY,
        CMD_REJECT
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [2:0] row;
        logic [2:0] column;
        logic       occupied;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

>>> sv/gnos_front.sv
// ----------------------------------------------------------------------------
// gnos_front
// Accepts request items, checks them against the grid in use and turns them
// into commands for the back end. Out-of-range writes are dropped.
// ----------------------------------------------------------------------------
module gnos_front import gnos_pkg::*; (
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,      // row[2:0], column[5:3], occupied[6]
    input  logic       i_kind,      // kind
    input  logic [3:0] i_side,
    input  logic       i_clearing,
    input  t_q_stat    i_q_stat,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [2:0] row;
    logic [2:0] column;
    logic       in_grid;

    assign row     = i_data[2:0];
    assign column  = i_data[5:3];
    assign in_grid = (4'(row) < i_side) && (4'(column) < i_side);

    assign o_ready = !i_clearing && !i_q_stat.full;

    always_comb begin
        o_cmd.row      = row;
        o_cmd.column   = column;
        o_cmd.occupied = i_data[6];
        o_push         = 1'b0;
        if (i_kind) begin
            o_cmd.op = in_grid ? CMD_QUERY : CMD_REJECT;
            o_push   = i_valid && o_ready;
        end else begin
            o_cmd.op = CMD_WRITE;
            // drop writes outside the grid in use
            o_push   = i_valid && o_ready && in_grid;
        end
    end

endmodule

>>> sv/gnos_queue.sv
// ----------------------------------------------------------------------------
// gnos_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module gnos_queue import gnos_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    t_cmd       r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_cmd        = r_buf[r_rp];
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_buf[r_wp] <= i_cmd;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> sv/gnos_back.sv
// ----------------------------------------------------------------------------
// gnos_back
// Holds the occupancy grid, executes writes and scans the grid one cell per
// cycle for queries; keeps the result in an output register.
// ----------------------------------------------------------------------------
module gnos_back import gnos_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [3:0]  i_side,
    input  logic [13:0] i_limit,
    input  t_q_stat     i_q_stat,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_clearing,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [2:0]  o_obs_row,
    output logic [2:0]  o_obs_col,
    output logic [6:0]  o_dist
);

    localparam int NCELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW     = $clog2(NCELLS);
    localparam int IW     = $clog2(GRID_SIDE);
    localparam int CW     = (IW > 3) ? IW : 3;
    localparam int DW     = 2 * CW + 1;
    localparam int LW     = (DW > 14) ? DW : 14;
    localparam int KW     = (IW > 4) ? IW : 4;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_LAST  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic [AW-1:0]   r_clr_addr;
    logic [IW-1:0]   r_i;
    logic [IW-1:0]   r_j;
    logic [2:0]      r_qr;
    logic [2:0]      r_qc;
    logic            r_reject;
    logic            r_pv;
    logic [IW-1:0]   r_pi;
    logic [IW-1:0]   r_pj;
    logic            r_rd_data;
    logic            r_found;
    logic            r_blocked;
    logic [DW-1:0]   r_best;
    logic [IW-1:0]   r_best_r;
    logic [IW-1:0]   r_best_c;
    logic            r_out_valid;
    logic [1:0]      r_out_status;
    logic [2:0]      r_out_row;
    logic [2:0]      r_out_col;
    logic [6:0]      r_out_dist;

    logic            mem [NCELLS];

    logic            last_i;
    logic            last_j;
    logic [AW-1:0]   scan_addr;
    logic [AW-1:0]   cmd_addr;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic            mem_wd;
    logic [CW-1:0]   dr;
    logic [CW-1:0]   dc;
    logic [2*CW-1:0] dr2;
    logic [2*CW-1:0] dc2;
    logic [DW-1:0]   cand_dist;
    logic            hit;
    logic            better;
    logic            out_free;
    logic [1:0]      fin_status;

    assign last_j    = (KW'(r_j) == KW'(i_side) - KW'(1));
    assign last_i    = (KW'(r_i) == KW'(i_side) - KW'(1));
    assign scan_addr = AW'(int'(r_i) * GRID_SIDE + int'(r_j));
    assign cmd_addr  = AW'(int'(i_cmd.row) * GRID_SIDE + int'(i_cmd.column));

    assign o_pop      = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_clearing = (r_state == S_CLEAR);

    assign mem_we = o_clearing || (o_pop && (i_cmd.op == CMD_WRITE));
    assign mem_wa = o_clearing ? r_clr_addr : cmd_addr;
    assign mem_wd = o_clearing ? 1'b0 : i_cmd.occupied;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[scan_addr];
    end

    // squared distance of the cell read last cycle
    assign dr     = (CW'(r_pi) > CW'(r_qr)) ? CW'(r_pi) - CW'(r_qr) : CW'(r_qr) - CW'(r_pi);
    assign dc     = (CW'(r_pj) > CW'(r_qc)) ? CW'(r_pj) - CW'(r_qc) : CW'(r_qc) - CW'(r_pj);
    assign dr2    = dr * dr;
    assign dc2    = dc * dc;
    assign cand_dist = DW'(dr2) + DW'(dc2);
    assign hit    = r_pv && r_rd_data;
    assign better = (LW'(cand_dist) < LW'(i_limit)) && (!r_found || (cand_dist < r_best));

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        if (r_reject) begin
            fin_status = ST_RANGE;
        end else if (r_blocked) begin
            fin_status = ST_BLOCKED;
        end else if (r_found) begin
            fin_status = ST_FOUND;
        end else begin
            fin_status = ST_NONE;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(NCELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_pop) begin
                    case (i_cmd.op)
                        CMD_QUERY:  n_state = S_SCAN;
                        CMD_REJECT: n_state = S_EMIT;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (last_i && last_j) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_SCAN);
            if (o_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (o_pop) begin
                r_qr      <= i_cmd.row;
                r_qc      <= i_cmd.column;
                r_reject  <= (i_cmd.op == CMD_REJECT);
                r_i       <= '0;
                r_j       <= '0;
                r_found   <= 1'b0;
                r_blocked <= 1'b0;
            end
            if (r_state == S_SCAN) begin
                r_pi <= r_i;
                r_pj <= r_j;
                if (last_j) begin
                    r_j <= '0;
                    r_i <= r_i + IW'(1);
                end else begin
                    r_j <= r_j + IW'(1);
                end
            end
            if (hit) begin
                if ((CW'(r_pi) == CW'(r_qr)) && (CW'(r_pj) == CW'(r_qc))) begin
                    r_blocked <= 1'b1;
                end
                if (better) begin
                    r_found  <= 1'b1;
                    r_best   <= cand_dist;
                    r_best_r <= r_pi;
                    r_best_c <= r_pj;
                end
            end
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid  <= 1'b1;
                r_out_status <= fin_status;
                if (fin_status == ST_FOUND) begin
                    r_out_row  <= 3'(r_best_r);
                    r_out_col  <= 3'(r_best_c);
                    r_out_dist <= (LW'(r_best) > LW'(DIST_MAX_OUT)) ?
                                  7'(DIST_MAX_OUT) : 7'(r_best);
                end else begin
                    r_out_row  <= 3'd0;
                    r_out_col  <= 3'd0;
                    r_out_dist <= 7'd0;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_status  = r_out_status;
    assign o_obs_row = r_out_row;
    assign o_obs_col = r_out_col;
    assign o_dist    = r_out_dist;

endmodule

>>> sv/grid_nearest_obstacle_search.sv
// Flow: a write passes the command queue and lands in the grid memory when the idle
//   back end pops it; a query scans side*side cells, reading one grid cell per cycle
//   from the memory, then passes S_LAST and S_EMIT before its answer is registered.
// Throughput: one write per cycle while no query is in progress; one query at a time.
// Reset: synchronous, active low; afterwards a clearing pass over all GRID_SIDE*GRID_SIDE
//   cells (64 by default) zeroes the grid while no request is accepted.
// ----------------------------------------------------------------------------
// grid_nearest_obstacle_search
// Occupancy grid with a nearest obstacle search by full row-major scan.
// ----------------------------------------------------------------------------
module grid_nearest_obstacle_search import gnos_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [13:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // row[2:0], column[5:3], occupied[6]
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // obstacle_row[2:0], obstacle_column[5:3],
                                        // distance_sq[12:6]
    output logic [1:0]  m_axis_tuser    // status
);

    logic [3:0]  r_side;
    logic [13:0] r_limit;
    logic [3:0]  side_act;
    logic        push;
    logic        pop;
    logic        clearing;
    t_cmd        front_cmd;
    t_cmd        q_cmd;
    t_q_stat     q_stat;
    logic [2:0]  obs_row;
    logic [2:0]  obs_col;
    logic [6:0]  obs_dist;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side  <= SIDE_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SIDE:  r_side  <= i_cfg_data[3:0];
                CFG_LIMIT: r_limit <= i_cfg_data;
                default:   r_side  <= r_side;
            endcase
        end
    end

    // sides beyond the built grid act as the full grid
    assign side_act = (int'(r_side) > GRID_SIDE) ? 4'(GRID_SIDE) : r_side;

    gnos_front u_front (
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_data     (s_axis_tdata),
        .i_kind     (s_axis_tuser),
        .i_side     (side_act),
        .i_clearing (clearing),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    gnos_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    gnos_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_side     (side_act),
        .i_limit    (r_limit),
        .i_q_stat   (q_stat),
        .i_cmd      (q_cmd),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_status   (m_axis_tuser),
        .o_obs_row  (obs_row),
        .o_obs_col  (obs_col),
        .o_dist     (obs_dist)
    );

    assign m_axis_tdata = {3'b000, obs_dist, obs_col, obs_row};

endmodule

>>> sv/gnos_checker.sv
// ----------------------------------------------------------------------------
// gnos_checker
// Port-level checks of the grid nearest obstacle search block.
// ----------------------------------------------------------------------------
module gnos_checker import gnos_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_FOUND) |-> (m_axis_tdata == 16'd0))
        else $error("nonzero fields without a found obstacle");

    // a distance of zero would mean the queried cell itself, which is blocked
    a_found_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FOUND) |-> (m_axis_tdata[12:6] != 7'd0))
        else $error("found obstacle at distance zero");

    a_clear_pass: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("request accepted before grid clear");

endmodule

bind grid_nearest_obstacle_search gnos_checker u_chk (.*);
